### design/palette_gradient_interpolator_core_defines.svh
// Assertion macros used by the checker file of the palette gradient core.
`ifndef PALETTE_GRADIENT_INTERPOLATOR_CORE_DEFINES_SVH
`define PALETTE_GRADIENT_INTERPOLATOR_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PGI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define PGI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define PGI_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### design/pgi_pkg.sv
`timescale 1ns / 1ps

package pgi_pkg;

    localparam int ValueW = 32;
    localparam int FracW  = 16;
    localparam int PairW  = 48;
    localparam int CountW = 4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef logic [1:0] t_status;

    localparam t_status StOk  = 2'd0;
    localparam t_status StNan = 2'd1;
    localparam t_status StFew = 2'd2;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CfgRangeLow   = 3'd0;
    localparam t_cfg_idx CfgRangeScale = 3'd1;
    localparam t_cfg_idx CfgStopCount  = 3'd2;
    localparam t_cfg_idx CfgPair0      = 3'd3;
    localparam t_cfg_idx CfgPair3      = 3'd6;

endpackage

### design/pgi_blend.sv
`timescale 1ns / 1ps

module pgi_blend (
    input  pgi_pkg::t_rgb                i_lo,
    input  pgi_pkg::t_rgb                i_hi,
    input  logic [pgi_pkg::FracW-1:0]    i_frac,
    output pgi_pkg::t_rgb                o_rgb
);

    function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                       input logic [pgi_pkg::FracW-1:0] f);
        logic [pgi_pkg::FracW:0] inv;
        logic [24:0]             acc;
        inv = 17'h10000 - {1'b0, f};
        acc = 25'(a) * 25'(inv) + 25'(b) * 25'(f);
        return acc[23:16];
    endfunction

    assign o_rgb.red   = mix(i_lo.red,   i_hi.red,   i_frac);
    assign o_rgb.green = mix(i_lo.green, i_hi.green, i_frac);
    assign o_rgb.blue  = mix(i_lo.blue,  i_hi.blue,  i_frac);

endmodule

### design/palette_gradient_interpolator_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// s         in         i_s_tvalid / o_s_tready   tdata sample_value, tuser sample_is_nan
// m         out        o_m_tvalid / i_m_tready   tdata red/green/blue, tuser status
// cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One sample per cycle while the output is not stalled; each result passes four registered stages.
// The four stages are difference, 32x32 multiply, clamp and split, blend.
// Reset is synchronous and active low; it empties the pipeline and zeroes the configuration registers.
// A stalled output holds its result while empty stages behind it keep filling.

module palette_gradient_interpolator_core #(
    parameter int MAX_STOPS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] sample_value
    input  logic [0:0]  i_s_tuser,   // [0] sample_is_nan
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic [1:0]  o_m_tuser,   // [1:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    localparam int IdxW = $clog2(MAX_STOPS);
    localparam logic [pgi_pkg::CountW-1:0] MaxCount = pgi_pkg::CountW'(MAX_STOPS);

    logic [31:0]                  r_range_low;
    logic [31:0]                  r_range_scale;
    logic [pgi_pkg::CountW-1:0]   r_stop_count;
    logic [pgi_pkg::PairW-1:0]    r_palette [4];

    logic                         r_v1, r_v2, r_v3, r_v4;
    pgi_pkg::t_status             r_st1, r_st2, r_st3, r_st4;
    logic [31:0]                  r_d1;
    logic [63:0]                  r_prod;
    logic [IdxW-1:0]              r_idx1, r_idx2;
    logic [pgi_pkg::FracW-1:0]    r_frac;
    pgi_pkg::t_rgb                r_rgb;

    logic                         w_en1, w_en2, w_en3, w_en4;
    logic [pgi_pkg::CountW-1:0]   w_count;
    logic [pgi_pkg::CountW-1:0]   w_last;
    logic [32:0]                  w_diff;
    pgi_pkg::t_status             n_st1;
    logic [31:0]                  n_d1;
    logic [31:0]                  w_ipart;
    logic                         w_clamp;
    logic [IdxW-1:0]              w_ipart_inc;
    pgi_pkg::t_rgb                w_lo, w_hi, w_mix;

    function automatic pgi_pkg::t_rgb stop_rgb(input logic [IdxW-1:0] idx,
                                               input logic [pgi_pkg::PairW-1:0] p0,
                                               input logic [pgi_pkg::PairW-1:0] p1,
                                               input logic [pgi_pkg::PairW-1:0] p2,
                                               input logic [pgi_pkg::PairW-1:0] p3);
        logic [2:0]                i3;
        logic [pgi_pkg::PairW-1:0] pair;
        i3 = 3'(idx);
        case (i3[2:1])
            2'd0:    pair = p0;
            2'd1:    pair = p1;
            2'd2:    pair = p2;
            default: pair = p3;
        endcase
        return i3[0] ? pgi_pkg::t_rgb'(pair[47:24]) : pgi_pkg::t_rgb'(pair[23:0]);
    endfunction

    assign w_en4       = !r_v4 || i_m_tready;
    assign w_en3       = !r_v3 || w_en4;
    assign w_en2       = !r_v2 || w_en3;
    assign w_en1       = !r_v1 || w_en2;
    assign o_s_tready  = w_en1;
    assign o_cfg_ready = 1'b1;

    assign w_count = (r_stop_count > MaxCount) ? MaxCount : r_stop_count;
    assign w_last  = w_count - pgi_pkg::CountW'(1);

    always_comb begin
        w_diff = {i_s_tdata[31], i_s_tdata} - {r_range_low[31], r_range_low};
        n_d1   = (!w_diff[32] && (w_diff != 33'd0)) ? w_diff[31:0] : 32'd0;
        if (i_s_tuser[0]) begin
            n_st1 = pgi_pkg::StNan;
        end else if (w_count < pgi_pkg::CountW'(2)) begin
            n_st1 = pgi_pkg::StFew;
        end else begin
            n_st1 = pgi_pkg::StOk;
        end
    end

    assign w_ipart     = r_prod[63:32];
    assign w_clamp     = w_ipart >= 32'(w_last);
    assign w_ipart_inc = w_ipart[IdxW-1:0] + IdxW'(1);

    assign w_lo = stop_rgb(r_idx1, r_palette[0], r_palette[1], r_palette[2], r_palette[3]);
    assign w_hi = stop_rgb(r_idx2, r_palette[0], r_palette[1], r_palette[2], r_palette[3]);

    pgi_blend u_blend (
        .i_lo   (w_lo),
        .i_hi   (w_hi),
        .i_frac (r_frac),
        .o_rgb  (w_mix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low   <= '0;
            r_range_scale <= '0;
            r_stop_count  <= '0;
            for (int i = 0; i < 4; i++) begin
                r_palette[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pgi_pkg::CfgRangeLow:   r_range_low   <= i_cfg_data[31:0];
                pgi_pkg::CfgRangeScale: r_range_scale <= i_cfg_data[31:0];
                pgi_pkg::CfgStopCount:  r_stop_count  <= i_cfg_data[pgi_pkg::CountW-1:0];
                default: begin
                    if (i_cfg_index inside {[pgi_pkg::CfgPair0 : pgi_pkg::CfgPair3]}) begin
                        r_palette[2'(i_cfg_index - pgi_pkg::CfgPair0)] <= i_cfg_data;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_s_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_d1  <= n_d1;
            r_st1 <= n_st1;
        end
        if (w_en2) begin
            r_prod <= 64'(r_d1) * 64'(r_range_scale);
            r_st2  <= r_st1;
        end
        if (w_en3) begin
            r_st3  <= r_st2;
            r_idx1 <= w_clamp ? w_last[IdxW-1:0] : w_ipart[IdxW-1:0];
            r_idx2 <= w_clamp ? w_last[IdxW-1:0] : w_ipart_inc;
            r_frac <= w_clamp ? '0 : r_prod[31:16];
        end
        if (w_en4) begin
            r_st4 <= r_st3;
            r_rgb <= (r_st3 == pgi_pkg::StOk) ? w_mix : '0;
        end
    end

    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = {r_rgb.blue, r_rgb.green, r_rgb.red};
    assign o_m_tuser  = r_st4;

endmodule

### design/pgi_checker.sv
`timescale 1ns / 1ps
`include "palette_gradient_interpolator_core_defines.svh"

module pgi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    `PGI_ASSERT_ALWAYS_NEXT(a_reset_empties, i_clk, !i_rst_n, !o_m_tvalid, "output valid after reset")

    `PGI_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")

    `PGI_ASSERT_NOW(a_status_legal, i_clk, i_rst_n, o_m_tvalid, o_m_tuser == pgi_pkg::StOk || o_m_tuser == pgi_pkg::StNan || o_m_tuser == pgi_pkg::StFew, "illegal status code")

    `PGI_ASSERT_NOW(a_error_black, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != pgi_pkg::StOk), o_m_tdata == 24'd0, "error result carries color")

endmodule

bind palette_gradient_interpolator_core pgi_checker u_pgi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

### bench/gradient_color_checker.sv
`timescale 1ns / 1ps

module gradient_color_checker
    import pgi_pkg::*;
#(
    parameter int MAX_STOPS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] sample_value
    input  logic [0:0]  i_s_tuser,   // [0] sample_is_nan
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic [1:0]  i_m_tuser,   // [1:0] status
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        t_rgb    rgb;
        t_status status;
    } color_result_t;

    logic [ValueW-1:0] range_low;
    logic [ValueW-1:0] range_scale;
    logic [CountW-1:0] stop_count;
    logic [PairW-1:0]  palette [4];

    color_result_t color_due [$];

    function automatic logic [23:0] stop_color(logic [2:0] idx);
        logic [PairW-1:0] pair;
        pair = palette[idx[2:1]];
        return idx[0] ? pair[47:24] : pair[23:0];
    endfunction

    function automatic logic [7:0] blend_channel(logic [7:0] a, logic [7:0] b,
                                                 logic [FracW-1:0] frac);
        logic [31:0] acc;
        acc = 32'(a) * (32'd65536 - 32'(frac)) + 32'(b) * 32'(frac);
        return acc[23:16];
    endfunction

    function automatic color_result_t gradient_color(logic [31:0] value, logic nan);
        color_result_t     res;
        logic [CountW-1:0] cnt;
        logic signed [32:0] diff;
        logic [63:0]       pos;
        logic [2:0]        lo_idx;
        logic [2:0]        hi_idx;
        logic [FracW-1:0]  frac;
        logic [23:0]       lo_rgb;
        logic [23:0]       hi_rgb;
        res = '0;
        if (nan) begin
            res.status = StNan;
            return res;
        end
        cnt = (stop_count > MAX_STOPS) ? CountW'(MAX_STOPS) : stop_count;
        if (cnt < 2) begin
            res.status = StFew;
            return res;
        end
        diff   = $signed({value[31], value}) - $signed({range_low[31], range_low});
        lo_idx = '0;
        hi_idx = '0;
        frac   = '0;
        if (diff > 0) begin
            pos = (64'(diff[31:0]) * 64'(range_scale)) >> FracW;
            if (pos >= (64'(cnt - 1) << FracW)) begin
                lo_idx = 3'(cnt - 1);
                hi_idx = lo_idx;
            end else begin
                lo_idx = pos[18:16];
                hi_idx = lo_idx + 3'd1;
                frac   = pos[15:0];
            end
        end
        lo_rgb = stop_color(lo_idx);
        hi_rgb = stop_color(hi_idx);
        res.rgb.red   = blend_channel(lo_rgb[23:16], hi_rgb[23:16], frac);
        res.rgb.green = blend_channel(lo_rgb[15:8], hi_rgb[15:8], frac);
        res.rgb.blue  = blend_channel(lo_rgb[7:0], hi_rgb[7:0], frac);
        res.status    = StOk;
        return res;
    endfunction

    always @(posedge i_clk) begin
        color_result_t want;
        color_result_t got;
        if (!i_rst_n) begin
            range_low   = '0;
            range_scale = '0;
            stop_count  = '0;
            for (int k = 0; k < 4; k++) begin
                palette[k] = '0;
            end
            color_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.rgb.red   = i_m_tdata[7:0];
                got.rgb.green = i_m_tdata[15:8];
                got.rgb.blue  = i_m_tdata[23:16];
                got.status    = i_m_tuser;
                if (color_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("unexpected result r=%h g=%h b=%h status=%0d",
                                 got.rgb.red, got.rgb.green, got.rgb.blue, got.status);
                    end
                end else begin
                    want = color_due.pop_front();
                    if (got.rgb.red !== want.rgb.red || got.rgb.green !== want.rgb.green ||
                        got.rgb.blue !== want.rgb.blue || got.status !== want.status) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("mismatch: expected r=%h g=%h b=%h status=%0d, got r=%h g=%h b=%h status=%0d",
                                     want.rgb.red, want.rgb.green, want.rgb.blue, want.status,
                                     got.rgb.red, got.rgb.green, got.rgb.blue, got.status);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                color_due.push_back(gradient_color(i_s_tdata, i_s_tuser[0]));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CfgRangeLow) begin
                    range_low = i_cfg_data[31:0];
                end else if (i_cfg_index == CfgRangeScale) begin
                    range_scale = i_cfg_data[31:0];
                end else if (i_cfg_index == CfgStopCount) begin
                    stop_count = i_cfg_data[CountW-1:0];
                end else if (i_cfg_index >= CfgPair0 && i_cfg_index <= CfgPair3) begin
                    palette[2'(i_cfg_index - CfgPair0)] = i_cfg_data;
                end
            end
        end
        o_pending = color_due.size();
    end

endmodule

### bench/tb_palette_gradient_interpolator_core.sv
`timescale 1ns / 1ps

module tb_palette_gradient_interpolator_core;
    import pgi_pkg::*;

    localparam int       MaxStops   = 8;
    localparam int       CycleLimit = 300000;
    localparam t_cfg_idx CfgSpare   = 3'd7;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata   = '0;
    logic [0:0]  i_s_tuser   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [23:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index = '0;
    logic [47:0] i_cfg_data  = '0;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int out_hold    = 0;
    bit no_stall    = 1'b0;

    logic [31:0] cur_low;
    logic [31:0] cur_scale;
    logic [3:0]  cur_count;
    logic [47:0] cur_pal [4];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    palette_gradient_interpolator_core #(
        .MAX_STOPS(MaxStops)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    gradient_color_checker #(
        .MAX_STOPS(MaxStops)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("tb_palette_gradient_interpolator_core NOT OK");
            $finish;
        end
    end

    // The receiver draws a fresh stall after every result transfer, unless no_stall is set.
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            out_hold = no_stall ? 0 : $urandom_range(0, 7);
        end else if (out_hold > 0) begin
            out_hold--;
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= (out_hold == 0);
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
    endtask

    task automatic load_setting();
        cfg_write(CfgRangeLow, {16'($urandom), cur_low});
        cfg_write(CfgRangeScale, {16'($urandom), cur_scale});
        cfg_write(CfgSpare, 48'({$urandom, $urandom}));
        cfg_write(CfgStopCount, {44'({$urandom, $urandom}), cur_count});
        for (int k = 0; k < 4; k++) begin
            cfg_write(CfgPair0 + t_cfg_idx'(k), cur_pal[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [31:0] value, input logic nan);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid   <= 1'b1;
        i_s_tdata    <= value;
        i_s_tuser[0] <= nan;
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    initial begin
        int          eff_count;
        int          pick;
        longint      width;
        longint      offset;
        longint      span;
        logic [63:0] wide_scale;
        logic [31:0] value;
        logic        nan;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Registers still at reset: no usable palette.
        send_sample(32'h0000_0000, 1'b0);
        send_sample($urandom, 1'b1);
        settle();

        // Identity mapping over eight stops.
        cur_low    = 32'h0000_0000;
        cur_scale  = 32'h0001_0000;
        cur_count  = 4'd8;
        cur_pal[0] = {24'hFFFFFF, 24'h000000};
        cur_pal[1] = {24'h123456, 24'hFF00FF};
        cur_pal[2] = {24'hA5A5A5, 24'h5A5A5A};
        cur_pal[3] = {24'h00FFFF, 24'hC0FFEE};
        load_setting();
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_8000, 1'b0);
        send_sample(32'h0000_FFFF, 1'b0);
        send_sample(32'h0001_8000, 1'b0);
        send_sample(32'h0006_FFFF, 1'b0);
        send_sample(32'h0007_0000, 1'b0);
        send_sample(32'h0003_5555, 1'b0);
        send_sample(32'h0001_8000, 1'b1);
        settle();

        // Widest difference times the largest scale, with an oversized count.
        cur_low   = 32'h8000_0000;
        cur_scale = 32'hFFFF_FFFF;
        cur_count = 4'hF;
        load_setting();
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h8000_0001, 1'b0);
        send_sample(32'h8001_0000, 1'b0);
        settle();

        cur_low   = 32'h7FFF_FFFF;
        cur_scale = 32'h0000_0000;
        cur_count = 4'd1;
        load_setting();
        send_sample(32'h1234_5678, 1'b0);
        settle();
        cur_count = 4'd2;
        load_setting();
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        settle();

        cur_low   = 32'hFFFF_0000;
        cur_scale = 32'h0000_8000;
        cur_count = 4'd9;
        load_setting();
        send_sample(32'h000D_0000, 1'b0);
        send_sample(32'h000C_0000, 1'b0);
        settle();

        for (int phase = 0; phase < 8; phase++) begin
            no_stall = (phase % 4 == 1);
            cur_low  = $urandom;
            if ($urandom_range(0, 9) < 8) begin
                cur_count = 4'($urandom_range(2, 8));
            end else begin
                cur_count = 4'($urandom);
            end
            eff_count = (cur_count > MaxStops) ? MaxStops : int'(cur_count);
            width = longint'($urandom_range(1, 16'hFFFF)) << $urandom_range(0, 15);
            if (eff_count < 2 || $urandom_range(0, 7) == 0) begin
                cur_scale = $urandom;
            end else begin
                wide_scale = (64'(eff_count - 1) << 32) / 64'(width);
                cur_scale  = (wide_scale > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide_scale[31:0];
            end
            if (phase == 6) begin
                cur_scale = 32'hFFFF_FFFF;
            end
            for (int k = 0; k < 4; k++) begin
                cur_pal[k] = 48'({$urandom, $urandom});
            end
            load_setting();
            span = width + width / 4;
            if (span > 64'hFFFF_FFFF) begin
                span = 64'hFFFF_FFFF;
            end
            for (int n = 0; n < 135; n++) begin
                pick = $urandom_range(0, 99);
                nan  = (pick < 8);
                if (pick < 25) begin
                    value = $urandom;
                end else begin
                    offset = longint'($urandom_range(0, 32'(span))) - width / 8;
                    value  = 32'(longint'($signed(cur_low)) + offset);
                end
                send_sample(value, nan);
                if (phase == 2 && n == 60) begin
                    settle();
                end
            end
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("tb_palette_gradient_interpolator_core OK");
        end else begin
            $display("tb_palette_gradient_interpolator_core NOT OK");
        end
        $finish;
    end

endmodule
